### rtl/crgc_pkg.sv
`default_nettype none

package crgc_pkg;

   // fixed point: one = 2^60
   localparam logic signed [63:0] Q_ONE         = 64'sh1000_0000_0000_0000;
   localparam logic signed [63:0] PI_Q60        = 64'sh3243_F6A8_885A_308D;
   localparam logic signed [63:0] GAIN_INV_Q60  = 64'sd700114967507363320;
   localparam logic signed [63:0] UDEG_TO_Q60   = 64'sd20122276272;
   localparam logic [63:0]        SMUL_CAP      = 64'h4000_0000_0000_0000;

   // angle reduction in microdegrees
   localparam logic signed [31:0] FULL_TURN     = 32'sd360000000;
   localparam logic signed [31:0] HALF_TURN     = 32'sd180000000;
   localparam logic signed [31:0] QUARTER_TURN  = 32'sd90000000;

   // route length
   localparam logic [39:0]        LEN_MAX       = 40'hFF_FFFF_FFFF;
   localparam logic [23:0]        RADIUS_RESET  = 24'd6378388;

   // shared unit sizes
   localparam int                 MUL_PARTS     = 4;
   localparam int                 SQRT_STEPS    = 32;
   localparam int                 SQRT_TOP_BIT  = 62;
   localparam int                 ATAN_DEPTH    = 64;
   localparam int                 ATAN_IW       = 6;

   typedef logic signed [63:0] atan_table_type [ATAN_DEPTH];

   typedef struct packed {
      logic              start;
      logic              vector_mode;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_cmd_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_res_type;

   typedef struct packed {
      logic         done;
      logic         neg;
      logic [127:0] mag;
   } mul_res_type;

   // arctangent table: entry 0 is pi/4, the rest the truncated series of atan(2^-i)
   function automatic atan_table_type atan_build();
      atan_table_type    t;
      logic signed [63:0] acc;
      logic [63:0]       num;
      logic [63:0]       quo;
      logic [64:0]       rem;
      logic [64:0]       den;
      int                e;
      for (int i = 0; i < ATAN_DEPTH; i++) begin
         if (i == 0) begin
            t[i] = PI_Q60 >>> 2;
         end else begin
            acc = '0;
            for (int k = 0; k < 31; k++) begin
               e = i * (2 * k + 1);
               if (e <= 60) begin
                  num = 64'd1 << (60 - e);
                  den = 65'(2 * k + 1);
                  rem = '0;
                  quo = '0;
                  // restoring long division
                  for (int b = 63; b >= 0; b--) begin
                     rem = {rem[63:0], num[b]};
                     if (rem >= den) begin
                        rem    = rem - den;
                        quo[b] = 1'b1;
                     end
                  end
                  if ((k % 2) == 1) acc = acc - $signed(quo);
                  else              acc = acc + $signed(quo);
               end
            end
            t[i] = acc;
         end
      end
      return t;
   endfunction

   localparam atan_table_type ATAN_ROM = atan_build();

endpackage

`default_nettype wire

### rtl/crgc_mul.sv
`default_nettype none

module crgc_mul import crgc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] op_a,
   input  wire logic signed [63:0] op_b,
   output mul_res_type             res
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  pp_ff, pp_in;
   logic [6:0]   sh_ff, sh_in;
   logic         pp_vld_ff, pp_vld_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  a_part, b_part;
   logic [1:0]   part_sum;

   // 32x32 partial product selected by the part counter
   assign a_part   = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_part   = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign part_sum = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0]};

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      pp_in     = pp_ff;
      sh_in     = sh_ff;
      pp_vld_in = 1'b0;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         a_in    = op_a[63] ? 64'(-op_a) : 64'(op_a);
         b_in    = op_b[63] ? 64'(-op_b) : 64'(op_b);
         neg_in  = op_a[63] ^ op_b[63];
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // product stage
         if (cnt_ff < 3'(MUL_PARTS)) begin
            pp_in     = a_part * b_part;
            sh_in     = {part_sum, 5'b0};
            pp_vld_in = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
         end
         // accumulate stage
         if (pp_vld_ff) begin
            acc_in = acc_ff + ({64'b0, pp_ff} << sh_ff);
            if (cnt_ff == 3'(MUL_PARTS)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         pp_vld_ff <= pp_vld_in;
         cnt_ff    <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
   end

   assign res.done = done_ff;
   assign res.neg  = neg_ff;
   assign res.mag  = acc_ff;

endmodule

`default_nettype wire

### rtl/crgc_cordic.sv
`default_nettype none

module crgc_cordic import crgc_pkg::*; #(
   parameter int STEPS = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  cordic_cmd_type cmd,
   output cordic_res_type res
);

   localparam int CW = $clog2(STEPS);

   logic signed [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [63:0] xs, ys, at;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               vec_ff, vec_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               plus;

   // one micro-rotation per cycle
   assign xs   = x_ff >>> cnt_ff;
   assign ys   = y_ff >>> cnt_ff;
   assign at   = ATAN_ROM[ATAN_IW'(cnt_ff)];
   assign plus = vec_ff ? (y_ff <= 64'sd0) : (z_ff >= 64'sd0);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      vec_in  = vec_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in    = cmd.x;
         y_in    = cmd.y;
         z_in    = cmd.z;
         vec_in  = cmd.vector_mode;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (plus) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = CW'(cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      vec_ff <= vec_in;
   end

   assign res.done = done_ff;
   assign res.x    = x_ff;
   assign res.y    = y_ff;
   assign res.z    = z_ff;

endmodule

`default_nettype wire

### rtl/crgc_isqrt.sv
`default_nettype none

module crgc_isqrt import crgc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [4:0]  k_ff, k_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] bit_val;
   logic [63:0] trial;

   // digit-by-digit root, one result bit per cycle
   assign bit_val = 64'd1 << (6'(SQRT_TOP_BIT) - {k_ff, 1'b0});
   assign trial   = res_ff + bit_val;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_val;
         end else begin
            res_in = res_ff >> 1;
         end
         if (k_ff == 5'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

### rtl/closed_route_great_circle_length_top.sv
// channel | ports                                              | beat
// --------+----------------------------------------------------+---------------------------
// req     | req_valid req_ready req_latitude_udeg ...           | one waypoint
// rsp     | rsp_valid rsp_ready rsp_route_length_mm ...         | one closed route length
// csr     | csr_write_enable csr_write_data                     | sphere radius in metres
//
// the first point of a route only records the start, unless it is final; every other point
// runs one leg, a final point two legs and then the emit step, each leg on the shared CORDIC,
// multiplier and root units; angle reduction adds or removes one turn per step.
// reset clears the route and loads the radius 6378388; there is no clearing pass.
// req_ready is high only while the sequencer is idle; the result sits in an output
// register, and a finished route waits in the emit step only while the previous beat is not yet taken.
`default_nettype none

module closed_route_great_circle_length_top import crgc_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [27:0] req_latitude_udeg,
   input  wire logic signed [28:0] req_longitude_udeg,
   input  wire logic               req_final_point,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [39:0]             rsp_route_length_mm,
   output logic                    rsp_length_saturated,
   input  wire logic               csr_write_enable,
   input  wire logic [23:0]        csr_write_data
);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_DISPATCH = 13'b0000000000010,
      ST_LOAD_ANG = 13'b0000000000100,
      ST_REDUCE   = 13'b0000000001000,
      ST_FOLD     = 13'b0000000010000,
      ST_CONV     = 13'b0000000100000,
      ST_ROT      = 13'b0000001000000,
      ST_PROD     = 13'b0000010000000,
      ST_CSUM     = 13'b0000100000000,
      ST_SQRT     = 13'b0001000000000,
      ST_VEC      = 13'b0010000000000,
      ST_LEGMUL   = 13'b0100000000000,
      ST_EMIT     = 13'b1000000000000
   } state_type;

   localparam logic [1:0] ANG_LAT1  = 2'd0;
   localparam logic [1:0] ANG_LAT2  = 2'd1;
   localparam logic [1:0] ANG_DLON  = 2'd2;
   localparam logic [1:0] PRD_SS    = 2'd0;
   localparam logic [1:0] PRD_CC    = 2'd1;
   localparam logic [1:0] PRD_CCD   = 2'd2;
   localparam logic       PASS_OUT  = 1'b0;
   localparam logic       PASS_BACK = 1'b1;
   localparam logic       ROOT_A    = 1'b0;
   localparam logic       ROOT_B    = 1'b1;

   state_type          state_ff, state_in;
   logic [23:0]        radius_ff, radius_in;
   logic signed [27:0] cur_lat_ff, cur_lat_in, start_lat_ff, start_lat_in;
   logic signed [27:0] prev_lat_ff, prev_lat_in;
   logic signed [28:0] cur_lon_ff, cur_lon_in, start_lon_ff, start_lon_in;
   logic signed [28:0] prev_lon_ff, prev_lon_in;
   logic               cur_fin_ff, cur_fin_in;
   logic [39:0]        running_ff, running_in;
   logic               sat_ff, sat_in;
   logic               started_ff, started_in;
   logic               pass_ff, pass_in;
   logic [1:0]         ang_idx_ff, ang_idx_in;
   logic signed [31:0] red_ff, red_in;
   logic [26:0]        m_ff, m_in;
   logic               neg_s_ff, neg_s_in, neg_c_ff, neg_c_in;
   logic signed [63:0] sin_ff [3];
   logic signed [63:0] sin_in [3];
   logic signed [63:0] cos_ff [3];
   logic signed [63:0] cos_in [3];
   logic [1:0]         prod_idx_ff, prod_idx_in;
   logic signed [63:0] p1_ff, p1_in, p3_ff, p3_in, c_ff, c_in;
   logic               root_idx_ff, root_idx_in;
   logic [31:0]        sa_ff, sa_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_len_ff, rsp_len_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic               mul_start;
   logic signed [63:0] mul_a, mul_b;
   mul_res_type        mul_res;
   cordic_cmd_type     cor_cmd;
   cordic_res_type     cor_res;
   logic               sqrt_start;
   logic [63:0]        sqrt_n;
   logic               sqrt_done;
   logic [31:0]        sqrt_root;

   logic signed [27:0] lat1, lat2;
   logic signed [28:0] lon1, lon2;
   logic signed [31:0] ang_sel, fold_r1, fold_r2;
   logic               fold_half, fold_quarter;
   logic [29:0]        m7;
   logic signed [63:0] smul_q, c_sum, c_clamp, theta2, theta;
   logic [63:0]        radius_k;
   logic [41:0]        leg_sum;

   crgc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .res   (mul_res)
   );

   crgc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_cmd),
      .res   (cor_res)
   );

   crgc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_n),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // leg endpoints: outbound leg is previous to current, closing leg is current to start
   assign lat1 = (pass_ff == PASS_BACK) ? cur_lat_ff   : prev_lat_ff;
   assign lon1 = (pass_ff == PASS_BACK) ? cur_lon_ff   : prev_lon_ff;
   assign lat2 = (pass_ff == PASS_BACK) ? start_lat_ff : cur_lat_ff;
   assign lon2 = (pass_ff == PASS_BACK) ? start_lon_ff : cur_lon_ff;

   always_comb begin
      unique case (ang_idx_ff)
         ANG_LAT1: ang_sel = 32'(lat1);
         ANG_LAT2: ang_sel = 32'(lat2);
         ANG_DLON: ang_sel = 32'(lon2) - 32'(lon1);
         default:  ang_sel = '0;
      endcase
   end

   // fold a reduced angle into the first quadrant
   assign fold_half    = (red_ff >= HALF_TURN);
   assign fold_r1      = fold_half ? (red_ff - HALF_TURN) : red_ff;
   assign fold_quarter = (fold_r1 > QUARTER_TURN);
   assign fold_r2      = fold_quarter ? (HALF_TURN - fold_r1) : fold_r1;
   assign m7           = {m_ff, 3'b000} - 30'(m_ff);

   // signed Q60 product with magnitude cap
   always_comb begin
      logic [63:0] mag;
      mag = mul_res.mag[123:60];
      if (mag > SMUL_CAP) mag = SMUL_CAP;
      smul_q = mul_res.neg ? -$signed(mag) : $signed(mag);
   end

   // cosine of the central angle, clamped to [-1, 1]
   assign c_sum   = p1_ff + p3_ff;
   assign c_clamp = (c_sum > Q_ONE) ? Q_ONE : ((c_sum < -Q_ONE) ? -Q_ONE : c_sum);

   // central angle clamped to [0, pi]
   assign theta2 = cor_res.z <<< 1;
   assign theta  = theta2[63] ? 64'sd0 : ((theta2 > PI_Q60) ? PI_Q60 : theta2);

   // radius in millimetres, times 1000 as shifts
   assign radius_k = ({40'b0, radius_ff} << 10) - ({40'b0, radius_ff} << 4)
                   - ({40'b0, radius_ff} << 3);
   assign leg_sum  = 42'(running_ff) + mul_res.mag[101:60];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      radius_in   = radius_ff;
      cur_lat_in  = cur_lat_ff;
      cur_lon_in  = cur_lon_ff;
      cur_fin_in  = cur_fin_ff;
      start_lat_in = start_lat_ff;
      start_lon_in = start_lon_ff;
      prev_lat_in = prev_lat_ff;
      prev_lon_in = prev_lon_ff;
      running_in  = running_ff;
      sat_in      = sat_ff;
      started_in  = started_ff;
      pass_in     = pass_ff;
      ang_idx_in  = ang_idx_ff;
      red_in      = red_ff;
      m_in        = m_ff;
      neg_s_in    = neg_s_ff;
      neg_c_in    = neg_c_ff;
      sin_in      = sin_ff;
      cos_in      = cos_ff;
      prod_idx_in = prod_idx_ff;
      p1_in       = p1_ff;
      p3_in       = p3_ff;
      c_in        = c_ff;
      root_idx_in = root_idx_ff;
      sa_in       = sa_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_sat_in  = rsp_sat_ff;
      mul_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      cor_cmd     = '0;
      sqrt_start  = 1'b0;
      sqrt_n      = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (csr_write_enable) radius_in = csr_write_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_lat_in = req_latitude_udeg;
               cur_lon_in = req_longitude_udeg;
               cur_fin_in = req_final_point;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!started_ff) begin
               if (cur_fin_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  start_lat_in = cur_lat_ff;
                  start_lon_in = cur_lon_ff;
                  prev_lat_in  = cur_lat_ff;
                  prev_lon_in  = cur_lon_ff;
                  running_in   = '0;
                  sat_in       = 1'b0;
                  started_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               pass_in    = PASS_OUT;
               ang_idx_in = ANG_LAT1;
               state_in   = ST_LOAD_ANG;
            end
         end
         ST_LOAD_ANG: begin
            red_in   = ang_sel;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            // modulo a full turn by repeated add or subtract
            priority if (red_ff[31]) begin
               red_in = red_ff + FULL_TURN;
            end else if (red_ff >= FULL_TURN) begin
               red_in = red_ff - FULL_TURN;
            end else begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            m_in      = 27'(fold_r2);
            neg_s_in  = fold_half;
            neg_c_in  = fold_half ^ fold_quarter;
            mul_start = 1'b1;
            mul_a     = {37'b0, fold_r2[26:0]};
            mul_b     = UDEG_TO_Q60;
            state_in  = ST_CONV;
         end
         ST_CONV: begin
            if (mul_res.done) begin
               cor_cmd.start       = 1'b1;
               cor_cmd.vector_mode = 1'b0;
               cor_cmd.x           = GAIN_INV_Q60;
               cor_cmd.y           = '0;
               cor_cmd.z           = $signed(mul_res.mag[63:0] + 64'(m7 >> 4));
               state_in            = ST_ROT;
            end
         end
         ST_ROT: begin
            if (cor_res.done) begin
               sin_in[ang_idx_ff] = neg_s_ff ? -cor_res.y : cor_res.y;
               cos_in[ang_idx_ff] = neg_c_ff ? -cor_res.x : cor_res.x;
               if (ang_idx_ff == ANG_DLON) begin
                  mul_start   = 1'b1;
                  mul_a       = sin_ff[ANG_LAT1];
                  mul_b       = sin_ff[ANG_LAT2];
                  prod_idx_in = PRD_SS;
                  state_in    = ST_PROD;
               end else begin
                  ang_idx_in = ang_idx_ff + 2'd1;
                  state_in   = ST_LOAD_ANG;
               end
            end
         end
         ST_PROD: begin
            if (mul_res.done) begin
               unique case (prod_idx_ff)
                  PRD_SS: begin
                     p1_in       = smul_q;
                     mul_start   = 1'b1;
                     mul_a       = cos_ff[ANG_LAT1];
                     mul_b       = cos_ff[ANG_LAT2];
                     prod_idx_in = PRD_CC;
                  end
                  PRD_CC: begin
                     mul_start   = 1'b1;
                     mul_a       = smul_q;
                     mul_b       = cos_ff[ANG_DLON];
                     prod_idx_in = PRD_CCD;
                  end
                  PRD_CCD: begin
                     p3_in    = smul_q;
                     state_in = ST_CSUM;
                  end
                  default: state_in = ST_CSUM;
               endcase
            end
         end
         ST_CSUM: begin
            c_in        = c_clamp;
            sqrt_start  = 1'b1;
            sqrt_n      = $unsigned(Q_ONE - c_clamp) << 2;
            root_idx_in = ROOT_A;
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               if (root_idx_ff == ROOT_A) begin
                  sa_in       = sqrt_root;
                  sqrt_start  = 1'b1;
                  sqrt_n      = $unsigned(Q_ONE + c_ff) << 2;
                  root_idx_in = ROOT_B;
               end else begin
                  // acos(c) = 2 atan2(sqrt(1-c), sqrt(1+c))
                  cor_cmd.start       = 1'b1;
                  cor_cmd.vector_mode = 1'b1;
                  cor_cmd.x           = $signed(64'(sqrt_root) << 29);
                  cor_cmd.y           = $signed(64'(sa_ff) << 29);
                  cor_cmd.z           = '0;
                  state_in            = ST_VEC;
               end
            end
         end
         ST_VEC: begin
            if (cor_res.done) begin
               mul_start = 1'b1;
               mul_a     = $signed(radius_k);
               mul_b     = theta;
               state_in  = ST_LEGMUL;
            end
         end
         ST_LEGMUL: begin
            if (mul_res.done) begin
               // saturating route sum
               if (leg_sum >= {2'b00, LEN_MAX}) begin
                  running_in = LEN_MAX;
                  sat_in     = 1'b1;
               end else begin
                  running_in = leg_sum[39:0];
               end
               if (pass_ff == PASS_OUT) begin
                  prev_lat_in = cur_lat_ff;
                  prev_lon_in = cur_lon_ff;
                  if (cur_fin_ff) begin
                     pass_in    = PASS_BACK;
                     ang_idx_in = ANG_LAT1;
                     state_in   = ST_LOAD_ANG;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = running_ff;
               rsp_sat_in   = sat_ff;
               running_in   = '0;
               sat_in       = 1'b0;
               started_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         running_ff   <= '0;
         sat_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_lat_ff <= '0;
         start_lon_ff <= '0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         running_ff   <= running_in;
         sat_ff       <= sat_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         start_lat_ff <= start_lat_in;
         start_lon_ff <= start_lon_in;
         prev_lat_ff  <= prev_lat_in;
         prev_lon_ff  <= prev_lon_in;
      end
      cur_lat_ff  <= cur_lat_in;
      cur_lon_ff  <= cur_lon_in;
      cur_fin_ff  <= cur_fin_in;
      pass_ff     <= pass_in;
      ang_idx_ff  <= ang_idx_in;
      red_ff      <= red_in;
      m_ff        <= m_in;
      neg_s_ff    <= neg_s_in;
      neg_c_ff    <= neg_c_in;
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
      prod_idx_ff <= prod_idx_in;
      p1_ff       <= p1_in;
      p3_ff       <= p3_in;
      c_ff        <= c_in;
      root_idx_ff <= root_idx_in;
      sa_ff       <= sa_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_route_length_mm  = rsp_len_ff;
   assign rsp_length_saturated = rsp_sat_ff;

   // the shared units run one at a time
   a_one_unit_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_res.done, cor_res.done, sqrt_done}))
      else $error("more than one shared unit finished in the same cycle");

   // a new result beat comes only from the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!$past(rsp_valid) || $past(rsp_ready))) |-> $past(state_ff == ST_EMIT))
      else $error("result beat loaded outside the emit step");

   // a saturated route reports the maximum length
   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length_saturated) |-> (rsp_route_length_mm == LEN_MAX))
      else $error("saturated result below maximum length");

   // an accepted waypoint is dispatched next
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted waypoint not dispatched");

endmodule

`default_nettype wire
